/* rtl/core/lcd_pkg.sv */
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types, codes and constant tables of the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
package lcd_pkg;

	// input action codes
	localparam logic [1:0] ACT_INIT = 2'd0;
	localparam logic [1:0] ACT_CMD  = 2'd1;
	localparam logic [1:0] ACT_DATA = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_ENABLE_PULSE = 3'd0;
	localparam logic [2:0] REG_COMMAND_GAP  = 3'd1;
	localparam logic [2:0] REG_DATA_GAP     = 3'd2;
	localparam logic [2:0] REG_INIT_GAP     = 3'd3;
	localparam logic [2:0] REG_POWER_UP     = 3'd4;

	// register reset values
	localparam logic [17:0] RST_ENABLE_PULSE = 18'd10000;
	localparam logic [17:0] RST_COMMAND_GAP  = 18'd10000;
	localparam logic [17:0] RST_DATA_GAP     = 18'd400;
	localparam logic [17:0] RST_INIT_GAP     = 18'd50000;
	localparam logic [17:0] RST_POWER_UP     = 18'd150000;

	// run step layout
	localparam logic [4:0] INIT_BYTE_START = 5'd9;
	localparam logic [4:0] INIT_LAST_STEP  = 5'd28;
	localparam logic [4:0] BYTE_LAST_STEP  = 5'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_BYTE
	} lcd_state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;       // latch byte and select of an accepted word
		logic       sel_data;   // accepted word targets the data register
		logic       emit;       // produce the pin state of the current step
		logic       init_mode;  // current run is the init sequence
		logic [4:0] step;       // index of the pin state within the run
		logic       last;       // this pin state ends the run
	} lcd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;        // output register can take a new word
	} lcd_status_t;

	// single nibbles of the init wake-up: 3, 3, 3, then 2
	function automatic logic [3:0] init_nibble(input logic [1:0] idx);
		logic [3:0] nib;
		unique case (idx)
			2'd3:    nib = 4'h2;
			default: nib = 4'h3;
		endcase
		return nib;
	endfunction

	// command bytes that close the init sequence
	function automatic logic [7:0] init_command(input logic [2:0] idx);
		logic [7:0] cmd;
		unique case (idx)
			3'd0:    cmd = 8'h28;
			3'd1:    cmd = 8'h0C;
			3'd2:    cmd = 8'h06;
			3'd3:    cmd = 8'h01;
			3'd4:    cmd = 8'h80;
			default: cmd = 8'h00;
		endcase
		return cmd;
	endfunction

endpackage

/* rtl/core/lcd_ctrl.sv */
// ----------------------------------------------------------------------------
// lcd_ctrl
// Run controller: takes input words and steps through the pin states of a run.
// ----------------------------------------------------------------------------
module lcd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  lcd_pkg::lcd_status_t status,
	output lcd_pkg::lcd_cmd_t   cmd,
	output logic                busy
);

	lcd_pkg::lcd_state_t state_q;
	lcd_pkg::lcd_state_t state_d;
	logic [4:0]          step_q;
	logic [4:0]          step_d;
	logic                accept;
	logic                emit;
	logic                last;

	assign accept = in_valid && (state_q == lcd_pkg::ST_IDLE);
	assign emit   = (state_q != lcd_pkg::ST_IDLE) && status.slot_free;
	assign last   = ((state_q == lcd_pkg::ST_INIT) && (step_q == lcd_pkg::INIT_LAST_STEP)) ||
	                ((state_q == lcd_pkg::ST_BYTE) && (step_q == lcd_pkg::BYTE_LAST_STEP));

	// next state
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		unique case (state_q)
			lcd_pkg::ST_IDLE: begin
				step_d = '0;
				if (accept) begin
					priority if (action == lcd_pkg::ACT_INIT) begin
						state_d = lcd_pkg::ST_INIT;
					end else if (action == lcd_pkg::ACT_CMD || action == lcd_pkg::ACT_DATA) begin
						state_d = lcd_pkg::ST_BYTE;
					end else begin
						state_d = lcd_pkg::ST_IDLE;
					end
				end
			end
			lcd_pkg::ST_INIT, lcd_pkg::ST_BYTE: begin
				if (emit) begin
					if (last) begin
						state_d = lcd_pkg::ST_IDLE;
						step_d  = '0;
					end else begin
						step_d = step_q + 5'd1;
					end
				end
			end
			default: begin
				state_d = lcd_pkg::ST_IDLE;
				step_d  = '0;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = (state_q == lcd_pkg::ST_IDLE);
		busy          = (state_q != lcd_pkg::ST_IDLE);
		cmd.load      = accept;
		cmd.sel_data  = (action == lcd_pkg::ACT_DATA);
		cmd.emit      = emit;
		cmd.init_mode = (state_q == lcd_pkg::ST_INIT);
		cmd.step      = step_q;
		cmd.last      = last;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcd_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

/* rtl/core/lcd_dpath.sv */
// ----------------------------------------------------------------------------
// lcd_dpath
// Datapath: timing registers, byte under way, last bus state, output register.
// ----------------------------------------------------------------------------
module lcd_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [17:0]          cfg_data,
	input  logic [7:0]           data_byte,
	input  lcd_pkg::lcd_cmd_t    cmd,
	output lcd_pkg::lcd_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           bus_nibble,
	output logic                 reg_select,
	output logic                 enable_level,
	output logic [17:0]          hold_us,
	output logic                 last_of_run
);

	logic [17:0] enable_pulse_q;
	logic [17:0] command_gap_q;
	logic [17:0] data_gap_q;
	logic [17:0] init_gap_q;
	logic [17:0] power_up_q;

	logic [7:0]  byte_q;
	logic        sel_q;
	logic [3:0]  held_nibble_q;
	logic        held_select_q;

	logic        valid_q;
	logic [3:0]  nib_q;
	logic        sel_out_q;
	logic        en_q;
	logic [17:0] hold_q;
	logic        last_q;

	logic [2:0]  init_j;
	logic [4:0]  init_k;
	logic [7:0]  cur_byte;
	logic        cur_sel;
	logic [1:0]  phase;
	logic [3:0]  nib_d;
	logic        sel_d;
	logic        en_d;
	logic [17:0] hold_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_pulse_q <= lcd_pkg::RST_ENABLE_PULSE;
			command_gap_q  <= lcd_pkg::RST_COMMAND_GAP;
			data_gap_q     <= lcd_pkg::RST_DATA_GAP;
			init_gap_q     <= lcd_pkg::RST_INIT_GAP;
			power_up_q     <= lcd_pkg::RST_POWER_UP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcd_pkg::REG_ENABLE_PULSE: enable_pulse_q <= cfg_data;
				lcd_pkg::REG_COMMAND_GAP:  command_gap_q  <= cfg_data;
				lcd_pkg::REG_DATA_GAP:     data_gap_q     <= cfg_data;
				lcd_pkg::REG_INIT_GAP:     init_gap_q     <= cfg_data;
				lcd_pkg::REG_POWER_UP:     power_up_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// byte and register select of the word under way
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= data_byte;
			sel_q  <= cmd.sel_data;
		end
	end

	// pin state of the current step
	always_comb begin
		init_j   = 3'(cmd.step - 5'd1);
		init_k   = cmd.step - lcd_pkg::INIT_BYTE_START;
		cur_byte = byte_q;
		cur_sel  = sel_q;
		phase    = cmd.step[1:0];
		nib_d    = held_nibble_q;
		sel_d    = held_select_q;
		en_d     = 1'b0;
		hold_d   = power_up_q;
		if (cmd.init_mode) begin
			cur_byte = lcd_pkg::init_command(init_k[4:2]);
			cur_sel  = 1'b0;
			phase    = init_k[1:0];
		end
		priority if (cmd.init_mode && cmd.step == 5'd0) begin
			// power-up wait keeps the bus as it was
			nib_d  = held_nibble_q;
			sel_d  = held_select_q;
			en_d   = 1'b0;
			hold_d = power_up_q;
		end else if (cmd.init_mode && cmd.step < lcd_pkg::INIT_BYTE_START) begin
			// single wake-up nibbles
			nib_d  = lcd_pkg::init_nibble(init_j[2:1]);
			sel_d  = 1'b0;
			en_d   = ~init_j[0];
			hold_d = init_j[0] ? init_gap_q : enable_pulse_q;
		end else begin
			// byte as upper then lower nibble, each enable high then low
			nib_d  = phase[1] ? cur_byte[3:0] : cur_byte[7:4];
			sel_d  = cur_sel;
			en_d   = ~phase[0];
			hold_d = phase[0] ? (cur_sel ? data_gap_q : command_gap_q) : enable_pulse_q;
		end
	end

	// last state driven on the bus
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_nibble_q <= '0;
			held_select_q <= 1'b0;
		end else if (cmd.emit) begin
			held_nibble_q <= nib_d;
			held_select_q <= sel_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			nib_q     <= nib_d;
			sel_out_q <= sel_d;
			en_q      <= en_d;
			hold_q    <= hold_d;
			last_q    <= cmd.last;
		end
	end

	assign status.slot_free = !valid_q || out_ready;
	assign out_valid        = valid_q;
	assign bus_nibble       = nib_q;
	assign reg_select       = sel_out_q;
	assign enable_level     = en_q;
	assign hold_us          = hold_q;
	assign last_of_run      = last_q;

endmodule

/* rtl/core/char_lcd_nibble_sequencer.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Pin-state sequencer for a character LCD on a 4-bit data bus.
// ----------------------------------------------------------------------------
// Each input word is an init request, a command byte or a data byte; the block
// answers with a run of pin states (nibble, register select, enable level and
// hold time in microseconds), tlast marking the final one. A byte run has four
// pin states and an init run 29, one pin state per cycle as paced by the run
// step counter in the controller while the output register has room. A new
// word is taken while the last state of the previous run still waits in the
// output register. Action code 3 is accepted and produces nothing. Timing
// registers are to be written through the cfg port only while the block is
// idle; the block itself does not enforce this.
module char_lcd_nibble_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // action[1:0], data_byte[9:2], zero[15:10]
	// pin-state words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // bus_nibble[3:0], enable_level[4], hold_us[22:5], zero[23]
	output logic        m_tuser,   // reg_select
	output logic        m_tlast
);

	lcd_pkg::lcd_cmd_t    cmd;
	lcd_pkg::lcd_status_t status;
	logic                 busy;
	logic [3:0]           bus_nibble;
	logic                 enable_level;
	logic [17:0]          hold_us;

	// run control
	lcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.action   (s_tdata[1:0]),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	// pin-state datapath
	lcd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.data_byte    (s_tdata[9:2]),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.bus_nibble   (bus_nibble),
		.reg_select   (m_tuser),
		.enable_level (enable_level),
		.hold_us      (hold_us),
		.last_of_run  (m_tlast)
	);

	assign m_tdata = {1'b0, hold_us, enable_level, bus_nibble};

	// a pin state is only produced when the output register has room
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> status.slot_free)
		else $error("pin state produced while output register is full");

	// a run only starts from an accepted word
	assert property (@(posedge clk) disable iff (!arst_n) $rose(busy) |-> $past(s_tvalid && s_tready))
		else $error("run started without an accepted word");

	// a byte run never steps past its fourth state
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !cmd.init_mode) |-> (cmd.step <= lcd_pkg::BYTE_LAST_STEP))
		else $error("byte run step out of range");

endmodule

/* tb/tb_char_lcd_nibble_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer
// Self-checking bench for the 4-bit character LCD pin-state sequencer.
// ----------------------------------------------------------------------------
// A queue of input words feeds a clocked stream driver; every accepted word is
// expanded by a local predictor into the pin states the block has to emit, and
// a clocked monitor compares each output word field by field with the oldest
// expected state. Timing registers are rewritten between phases while idle,
// covering reset values, both range extremes and random settings. Both stream
// sides idle in random bursts, except in the final phase.
module tb_char_lcd_nibble_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	// codes and limits local to the bench
	localparam logic [1:0] ACT_UNUSED     = 2'd3;
	localparam logic [2:0] SPARE_INDEX_LO = 3'd5;
	localparam logic [2:0] SPARE_INDEX_HI = 3'd7;
	localparam logic [17:0] HOLD_MAX      = 18'h3FFFF;
	localparam logic [15:0] WAKE_NIBBLES  = 16'h2333;          // 3, 3, 3, 2 from low end
	localparam logic [39:0] WAKE_COMMANDS = 40'h80_01_06_0C_28; // first command in low byte
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_WORDS  = 55;
	localparam int RANDOM_PHASES = 6;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data;
	} lcd_word_t;

	typedef struct packed {
		logic [3:0]  nibble;
		logic        sel;
		logic        en;
		logic [17:0] hold;
		logic        last;
	} pin_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [17:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;     // action[1:0], data_byte[9:2], zero[15:10]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // bus_nibble[3:0], enable_level[4], hold_us[22:5], zero[23]
	logic        m_tuser;          // reg_select
	logic        m_tlast;

	char_lcd_nibble_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// bench state
	lcd_word_t   word_q[$];
	pin_state_t  pin_q[$];
	logic [17:0] timing_us [0:4];
	logic [3:0]  bus_nib_now = '0;
	logic        bus_sel_now = 1'b0;
	int          fails = 0;
	int          cycles = 0;
	int          src_rate = 0;
	int          sink_rate = 0;
	int          src_gap = 0;
	int          sink_gap = 0;
	lcd_word_t   drv_next;

	initial begin
		forever #6 clk = ~clk;
	end

	// one pin state of a run, tracks what the bus holds afterwards
	function automatic void drive_state(input logic [3:0] nib, input logic sel,
			input logic en, input logic [17:0] hold);
		pin_state_t ps;
		ps = '{nibble: nib, sel: sel, en: en, hold: hold, last: 1'b0};
		pin_q.push_back(ps);
		bus_nib_now = nib;
		bus_sel_now = sel;
	endfunction

	// enable pulse then enable low with the gap of its kind
	function automatic void drive_nibble(input logic [3:0] nib, input logic sel,
			input logic [17:0] gap);
		drive_state(nib, sel, 1'b1, timing_us[lcd_pkg::REG_ENABLE_PULSE]);
		drive_state(nib, sel, 1'b0, gap);
	endfunction

	// upper nibble first
	function automatic void drive_byte(input logic [7:0] data, input logic sel);
		logic [17:0] gap;
		gap = sel ? timing_us[lcd_pkg::REG_DATA_GAP] : timing_us[lcd_pkg::REG_COMMAND_GAP];
		drive_nibble(data[7:4], sel, gap);
		drive_nibble(data[3:0], sel, gap);
	endfunction

	// expected pin states for one accepted word
	function automatic void plan_pin_states(input logic [1:0] act, input logic [7:0] data);
		pin_state_t tail;
		int k;
		if (act == lcd_pkg::ACT_INIT) begin
			// power-up wait keeps whatever the bus last held
			drive_state(bus_nib_now, bus_sel_now, 1'b0, timing_us[lcd_pkg::REG_POWER_UP]);
			for (k = 0; k < 4; k++)
				drive_nibble(WAKE_NIBBLES[4*k +: 4], 1'b0, timing_us[lcd_pkg::REG_INIT_GAP]);
			for (k = 0; k < 5; k++)
				drive_byte(WAKE_COMMANDS[8*k +: 8], 1'b0);
		end else if (act == lcd_pkg::ACT_CMD) begin
			drive_byte(data, 1'b0);
		end else if (act == lcd_pkg::ACT_DATA) begin
			drive_byte(data, 1'b1);
		end else begin
			return;
		end
		tail = pin_q.pop_back();
		tail.last = 1'b1;
		pin_q.push_back(tail);
	endfunction

	task automatic cmp_field(input string name, input logic [17:0] want, input logic [17:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endtask

	task automatic check_pin_state();
		pin_state_t want;
		if (pin_q.size() == 0) begin
			$display("%0t: unexpected word, expected none, actual tdata %h tuser %b tlast %b",
				$time, m_tdata, m_tuser, m_tlast);
			fails++;
		end else begin
			want = pin_q.pop_front();
			cmp_field("bus_nibble", 18'(want.nibble), 18'(m_tdata[3:0]));
			cmp_field("enable_level", 18'(want.en), 18'(m_tdata[4]));
			cmp_field("hold_us", want.hold, m_tdata[22:5]);
			cmp_field("reg_select", 18'(want.sel), 18'(m_tuser));
			cmp_field("last_of_run", 18'(want.last), 18'(m_tlast));
		end
	endtask

	// input driver with random idle bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				plan_pin_states(s_tdata[1:0], s_tdata[9:2]);
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (word_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (src_rate != 0 && $urandom_range(0, 99) < src_rate) begin
					src_gap = $urandom_range(0, 13);
					s_tvalid <= 1'b0;
				end else begin
					drv_next = word_q.pop_front();
					s_tdata <= {6'b0, drv_next.data, drv_next.action};
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// output monitor with random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_pin_state();
			if (sink_gap != 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (sink_rate != 0 && $urandom_range(0, 99) < sink_rate) begin
				sink_gap = $urandom_range(0, 13);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic queue_word(input logic [1:0] act, input logic [7:0] data);
		word_q.push_back('{action: act, data: data});
	endtask

	// register write; caller lowers cfg_we after the last one of a batch
	task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx <= lcd_pkg::REG_POWER_UP)
			timing_us[idx] = val;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// all words sent, all states seen, then room for a silent unused word
	task automatic wait_idle();
		while (word_q.size() != 0 || s_tvalid || pin_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [17:0] pick_hold_us();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return HOLD_MAX;
			2:       return 18'($urandom_range(1, 20));
			default: return 18'($urandom);
		endcase
	endfunction

	function automatic int pick_rate();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 5;
			2:       return 20;
			default: return 50;
		endcase
	endfunction

	// stimulus and end of run
	initial begin
		int ph;
		int r;
		int counted;
		logic [1:0] act;

		timing_us[lcd_pkg::REG_ENABLE_PULSE] = lcd_pkg::RST_ENABLE_PULSE;
		timing_us[lcd_pkg::REG_COMMAND_GAP]  = lcd_pkg::RST_COMMAND_GAP;
		timing_us[lcd_pkg::REG_DATA_GAP]     = lcd_pkg::RST_DATA_GAP;
		timing_us[lcd_pkg::REG_INIT_GAP]     = lcd_pkg::RST_INIT_GAP;
		timing_us[lcd_pkg::REG_POWER_UP]     = lcd_pkg::RST_POWER_UP;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset timing: byte extremes, unused code, power-up wait after data
		src_rate = 20;
		sink_rate = 20;
		queue_word(lcd_pkg::ACT_INIT, 8'h00);
		queue_word(lcd_pkg::ACT_CMD, 8'h00);
		queue_word(lcd_pkg::ACT_CMD, 8'hFF);
		queue_word(lcd_pkg::ACT_DATA, 8'h00);
		queue_word(lcd_pkg::ACT_DATA, 8'hFF);
		queue_word(lcd_pkg::ACT_DATA, 8'hA5);
		queue_word(ACT_UNUSED, 8'hFF);
		queue_word(lcd_pkg::ACT_INIT, 8'hFF);
		queue_word(lcd_pkg::ACT_CMD, 8'h5A);
		queue_word(ACT_UNUSED, 8'h00);
		queue_word(lcd_pkg::ACT_DATA, 8'h3C);
		wait_idle();

		// zero enable pulse and other extremes, writes to spare indexes ignored
		write_reg(lcd_pkg::REG_ENABLE_PULSE, '0);
		write_reg(lcd_pkg::REG_COMMAND_GAP, HOLD_MAX);
		write_reg(lcd_pkg::REG_DATA_GAP, '0);
		write_reg(lcd_pkg::REG_INIT_GAP, HOLD_MAX);
		write_reg(lcd_pkg::REG_POWER_UP, '0);
		write_reg(SPARE_INDEX_LO, 18'h15555);
		write_reg(SPARE_INDEX_HI, HOLD_MAX);
		end_writes();
		queue_word(lcd_pkg::ACT_DATA, 8'h96);
		queue_word(lcd_pkg::ACT_INIT, 8'h00);
		queue_word(lcd_pkg::ACT_CMD, 8'hC3);
		wait_idle();

		write_reg(lcd_pkg::REG_ENABLE_PULSE, HOLD_MAX);
		write_reg(lcd_pkg::REG_COMMAND_GAP, '0);
		write_reg(lcd_pkg::REG_DATA_GAP, HOLD_MAX);
		write_reg(lcd_pkg::REG_INIT_GAP, '0);
		write_reg(lcd_pkg::REG_POWER_UP, HOLD_MAX);
		end_writes();
		queue_word(lcd_pkg::ACT_DATA, 8'h81);
		queue_word(lcd_pkg::ACT_CMD, 8'h7E);
		queue_word(lcd_pkg::ACT_INIT, 8'h00);
		wait_idle();

		// random phases, the final one without idling
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (r = lcd_pkg::REG_ENABLE_PULSE; r <= lcd_pkg::REG_POWER_UP; r++)
				write_reg(3'(r), pick_hold_us());
			write_reg(SPARE_INDEX_LO + 3'($urandom_range(0, 2)), 18'($urandom));
			end_writes();
			if (ph == RANDOM_PHASES - 1) begin
				src_rate = 0;
				sink_rate = 0;
			end else begin
				src_rate = pick_rate();
				sink_rate = pick_rate();
			end
			counted = 0;
			while (counted < PHASE_WORDS) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					act = lcd_pkg::ACT_INIT;
				else if (r < 50)
					act = lcd_pkg::ACT_CMD;
				else if (r < 93)
					act = lcd_pkg::ACT_DATA;
				else
					act = ACT_UNUSED;
				queue_word(act, 8'($urandom));
				if (act != ACT_UNUSED)
					counted++;
			end
			wait_idle();
		end

		if (fails == 0 && pin_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
